>>> src/rab_pkg.sv
`default_nettype none

package rab_pkg;

    // field widths
    localparam int OPCODE_W = 2;
    localparam int COORD_W  = 12;
    localparam int VALUE_W  = 24;
    localparam int RADIUS_W = 11;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 40;

    // datapath widths
    localparam int PROD_W   = 2 * COORD_W;        // one square
    localparam int R2_W     = PROD_W + 1;         // sum of two squares
    localparam int LIMSQ_W  = 2 * RADIUS_W;       // squared radius limit
    localparam int SUB_W    = R2_W + 1;           // shared subtractor
    localparam int BIN_W    = 14;                 // rounded root, up to 5793
    localparam int ACC_W    = SUM_W + 1;          // sum plus sample before clamp
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    // geometry
    localparam int RADIUS_CAP_DEF = 1024;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1024);

    // root iteration starts at the largest power of four below 2^R2_W
    localparam logic [R2_W-1:0] SQRT_TOP = R2_W'(1) << (R2_W - 1);

    // saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] AVG_POS_LIM = SUM_W'(8388607);
    localparam logic [SUM_W-1:0] AVG_NEG_LIM = SUM_W'(8388608);
    localparam logic [VALUE_W-1:0] AVG_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] AVG_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};

    // command codes
    localparam logic [OPCODE_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic [COORD_W-1:0]        pixel_x;
        logic [COORD_W-1:0]        pixel_y;
        logic signed [VALUE_W-1:0] pixel_value;
        logic [RADIUS_W-1:0]       read_bin;
    } cmd_t;

    typedef struct packed {
        logic [RADIUS_W-1:0]       bin_number;
        logic signed [VALUE_W-1:0] average;
        logic [CNT_W-1:0]          pixel_count;
        logic                      empty_res;
    } result_t;

endpackage

`default_nettype wire

>>> src/rab_sq_mul.sv
`default_nettype none

module rab_sq_mul (
    input  wire logic [rab_pkg::COORD_W-1:0] a,
    input  wire logic [rab_pkg::COORD_W-1:0] b,
    output logic      [rab_pkg::PROD_W-1:0]  prod
);
    import rab_pkg::*;

    // unsigned product, registered by the sequencer
    assign prod = PROD_W'(a) * PROD_W'(b);

endmodule

`default_nettype wire

>>> src/rab_sub_unit.sv
`default_nettype none

module rab_sub_unit (
    input  wire logic [rab_pkg::SUB_W-1:0] a,
    input  wire logic [rab_pkg::SUB_W-1:0] b,
    output logic      [rab_pkg::SUB_W-1:0] diff,
    output logic                           ge
);
    import rab_pkg::*;

    logic [SUB_W:0] full;

    // difference with borrow out; ge means a >= b
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[SUB_W-1:0];
    assign ge   = ~full[SUB_W];

endmodule

`default_nettype wire

>>> src/radial_average_binner_core.sv
`default_nettype none

// Accumulate: busy through the squares, the radius check, the 13-step integer square root through
// the shared subtractor and the memory update; a pixel outside the radius ends at the check.
// Read: the result strobe follows the bin read and the 40-step restoring division on the shared
// subtractor, or the bin read alone for an empty bin. Clear: busy while every bin is zeroed.
// Reset clears control state, then sweeps all RADIUS_CAP+1 bins to zero with busy high.
// Results are shown for one cycle only; the receiver cannot stall them.
module radial_average_binner_core #(
    parameter int RADIUS_CAP = rab_pkg::RADIUS_CAP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire rab_pkg::cmd_t               cmd,
    input  wire logic                        cfg_we,
    input  wire logic [rab_pkg::RADIUS_W-1:0] cfg_data,
    output logic                             valid,
    output rab_pkg::result_t                 result
);
    import rab_pkg::*;

    localparam int NBINS  = RADIUS_CAP + 1;
    localparam int ADDR_W = $clog2(NBINS);

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_LIM,
        ST_CHECK,
        ST_SQRT,
        ST_ROUND,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_RD_MEM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_DONE
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;

    logic [RADIUS_W-1:0] radius_reg;
    logic [R2_W-1:0]     r2_reg, r2_next;
    logic [LIMSQ_W-1:0]  limsq_reg, limsq_next;
    logic [R2_W-1:0]     v_reg, v_next;
    logic [R2_W-1:0]     res_reg, res_next;
    logic [R2_W-1:0]     bit_reg, bit_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                valid_reg, valid_next;
    result_t             result_reg, result_next;

    // bin memory
    entry_t            mem [NBINS];
    entry_t            rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    // shared units
    logic [COORD_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [SUB_W-1:0]   sub_a, sub_b, sub_diff;
    logic               sub_ge;

    // helpers
    logic [COORD_W-1:0] lim;
    logic [BIN_W-1:0]   bin_calc;
    logic [ACC_W-1:0]   acc_sum;
    logic [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]   cnt_inc;
    logic [SUM_W-1:0]   abs_sum;
    logic [CNT_W:0]     rem_sh;
    logic [SUM_W-1:0]   neg_mag;
    logic [VALUE_W-1:0] avg;
    logic               rd_in_range;

    rab_sq_mul u_mul (
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    rab_sub_unit u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    // effective radius limit
    assign lim = (COORD_W'(radius_reg) > COORD_W'(RADIUS_CAP)) ?
                 COORD_W'(RADIUS_CAP) : COORD_W'(radius_reg);

    // rounding: step up when the remainder exceeds the root
    assign bin_calc = sub_ge ? res_reg[BIN_W-1:0] : res_reg[BIN_W-1:0] + BIN_W'(1);

    // saturating accumulate
    assign acc_sum = {rd_data_reg.sum[SUM_W-1], rd_data_reg.sum}
                   + {{(ACC_W-VALUE_W){cmd_reg.pixel_value[VALUE_W-1]}}, cmd_reg.pixel_value};
    assign sum_sat = (acc_sum[ACC_W-1] != acc_sum[ACC_W-2]) ?
                     (acc_sum[ACC_W-1] ? SUM_MIN : SUM_MAX) : acc_sum[SUM_W-1:0];
    assign cnt_inc = (rd_data_reg.count == CNT_MAX) ? rd_data_reg.count
                                                    : rd_data_reg.count + CNT_W'(1);

    // division operands and result
    assign abs_sum = rd_data_reg.sum[SUM_W-1] ? (SUM_W'(0) - rd_data_reg.sum) : rd_data_reg.sum;
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign neg_mag = SUM_W'(0) - dvd_reg;
    assign rd_in_range = 32'(cmd_reg.read_bin) < NBINS;

    always_comb
    begin
        if (neg_reg)
        begin
            avg = (dvd_reg > AVG_NEG_LIM) ? AVG_MIN : neg_mag[VALUE_W-1:0];
        end
        else
        begin
            avg = (dvd_reg > AVG_POS_LIM) ? AVG_MAX : dvd_reg[VALUE_W-1:0];
        end
    end

    // read address
    assign rd_addr = (state_reg == ST_ACC_RD) ? bin_reg[ADDR_W-1:0] : ADDR_W'(cmd_reg.read_bin);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        r2_next       = r2_reg;
        limsq_next    = limsq_reg;
        v_next        = v_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        bin_next      = bin_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        step_next     = step_reg;
        clr_addr_next = clr_addr_reg;
        valid_next    = 1'b0;
        result_next   = result_reg;
        mul_a         = '0;
        mul_b         = '0;
        sub_a         = '0;
        sub_b         = '0;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.opcode)
                        OP_ACCUM: state_next = ST_SQ_X;
                        OP_READ:  state_next = ST_RD_MEM;
                        OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end

            // zero one bin a cycle
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == ADDR_W'(NBINS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            // squares through the shared multiplier
            ST_SQ_X:
            begin
                mul_a      = cmd_reg.pixel_x;
                mul_b      = cmd_reg.pixel_x;
                r2_next    = R2_W'(mul_p);
                state_next = ST_SQ_Y;
            end

            ST_SQ_Y:
            begin
                mul_a      = cmd_reg.pixel_y;
                mul_b      = cmd_reg.pixel_y;
                r2_next    = r2_reg + R2_W'(mul_p);
                state_next = ST_SQ_LIM;
            end

            ST_SQ_LIM:
            begin
                mul_a      = lim;
                mul_b      = lim;
                limsq_next = mul_p[LIMSQ_W-1:0];
                state_next = ST_CHECK;
            end

            // radius check, then root setup
            ST_CHECK:
            begin
                sub_a = SUB_W'(limsq_reg);
                sub_b = SUB_W'(r2_reg);
                if (sub_ge)
                begin
                    v_next     = r2_reg;
                    res_next   = '0;
                    bit_next   = SQRT_TOP;
                    state_next = ST_SQRT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // one digit of the integer root per cycle
            ST_SQRT:
            begin
                sub_a = SUB_W'(v_reg);
                sub_b = SUB_W'(res_reg | bit_reg);
                if (sub_ge)
                begin
                    v_next   = sub_diff[R2_W-1:0];
                    res_next = (res_reg >> 1) | bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    state_next = ST_ROUND;
                end
            end

            // round to nearest bin
            ST_ROUND:
            begin
                sub_a    = SUB_W'(res_reg);
                sub_b    = SUB_W'(v_reg);
                bin_next = bin_calc;
                if (32'(bin_calc) < NBINS)
                begin
                    state_next = ST_ACC_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_ACC_RD:
            begin
                state_next = ST_ACC_WR;
            end

            // write back sum and count
            ST_ACC_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = bin_reg[ADDR_W-1:0];
                mem_wdata.sum   = sum_sat;
                mem_wdata.count = cnt_inc;
                state_next      = ST_IDLE;
            end

            ST_RD_MEM:
            begin
                state_next = ST_DIV_LOAD;
            end

            // empty or out-of-range bin answers at once, otherwise set up the divide
            ST_DIV_LOAD:
            begin
                if (!rd_in_range || rd_data_reg.count == '0)
                begin
                    result_next.bin_number  = cmd_reg.read_bin;
                    result_next.average     = '0;
                    result_next.pixel_count = '0;
                    result_next.empty_res   = 1'b1;
                    valid_next              = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    cnt_next   = rd_data_reg.count;
                    neg_next   = rd_data_reg.sum[SUM_W-1];
                    dvd_next   = abs_sum;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                sub_a = SUB_W'(rem_sh);
                sub_b = SUB_W'(cnt_reg);
                rem_next = sub_ge ? sub_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                dvd_next = {dvd_reg[SUM_W-2:0], sub_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_DONE;
                end
            end

            // sign, clamp and present
            ST_DIV_DONE:
            begin
                result_next.bin_number  = cmd_reg.read_bin;
                result_next.average     = avg;
                result_next.pixel_count = cnt_reg;
                result_next.empty_res   = 1'b0;
                valid_next              = 1'b1;
                state_next              = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cmd_reg        <= '0;
            radius_reg     <= RADIUS_RST;
            r2_reg         <= '0;
            limsq_reg      <= '0;
            v_reg          <= '0;
            res_reg        <= '0;
            bit_reg        <= '0;
            bin_reg        <= '0;
            dvd_reg        <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            neg_reg        <= 1'b0;
            step_reg       <= '0;
            clr_addr_reg   <= '0;
            valid_reg      <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_data;
            end
            r2_reg       <= r2_next;
            limsq_reg    <= limsq_next;
            v_reg        <= v_next;
            res_reg      <= res_next;
            bit_reg      <= bit_next;
            bin_reg      <= bin_next;
            dvd_reg      <= dvd_next;
            rem_reg      <= rem_next;
            cnt_reg      <= cnt_next;
            neg_reg      <= neg_next;
            step_reg     <= step_next;
            clr_addr_reg <= clr_addr_next;
            valid_reg    <= valid_next;
            result_reg   <= result_next;
        end
    end

    // bin memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign busy   = (state_reg != ST_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

    // checks
    a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("result strobe without preceding work");

    a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe longer than one cycle");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (result.empty_res == (result.pixel_count == '0)))
        else $error("empty flag disagrees with pixel count");

    a_empty_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && result.empty_res) |-> (result.average == '0))
        else $error("empty bin with nonzero average");

    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> $onehot(bit_reg))
        else $error("root iteration bit lost");

endmodule

`default_nettype wire
